>>> hw/rtl/sest_pkg.sv
package sest_pkg;

    localparam int SLOTS = 4;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [7:0]  SENT_8  = 8'hFF;
    localparam logic [15:0] SENT_16 = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } sest_op_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_RANGE     = 3'd4
    } sest_status_t;

    typedef struct packed {
        logic [15:0] channel;
        logic [7:0]  slot;
        logic [7:0]  shelf;
        logic [15:0] conn_id;
    } sest_entry_t;

    typedef struct packed {
        sest_op_t    operation;
        logic [15:0] channel;
        logic [7:0]  slot;
        logic [7:0]  shelf;
        logic [15:0] conn_id;
        logic [7:0]  index;
    } sest_in_t;

    typedef struct packed {
        sest_status_t status;
        logic [2:0]   count;
        logic         entry_valid;
        logic [15:0]  out_channel;
        logic [7:0]   out_slot;
        logic [7:0]   out_shelf;
        logic [15:0]  out_conn_id;
    } sest_out_t;

    typedef struct packed {
        logic hit;
        logic free;
    } sest_cmp_t;

    function automatic logic [2:0] sat_count(input logic [CNT_W-1:0] c);
        logic [2:0] r;
        if (int'(c) > 7)
        begin
            r = 3'd7;
        end
        else
        begin
            r = 3'(c);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/source_endpoint_set_table.sv
// add and remove scan every entry in S_SCAN, then pass through S_FINISH before the done strobe;
// read and clear go straight from S_IDLE to S_FINISH; done is registered from S_FINISH
// a new command is accepted only while idle, so add and remove are paced by the scan,
// set by the single compare unit that visits one entry per cycle
// reset empties the table and leaves the block idle; results cannot be stalled
module source_endpoint_set_table
    import sest_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  sest_in_t  cmd,
    output logic      done,
    output sest_out_t result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t            state_reg;
    sest_in_t          cmd_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic              hit_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              done_reg;
    sest_out_t         result_reg;
    sest_out_t         result_next;

    sest_entry_t       entry_fields_reg [SLOTS];

    sest_entry_t       key;
    sest_entry_t       cur_entry;
    logic              cur_present;
    sest_cmp_t         cmp;
    logic              wr_en;
    logic              in_range;

    assign key.channel = cmd_reg.channel;
    assign key.slot    = cmd_reg.slot;
    assign key.shelf   = cmd_reg.shelf;
    assign key.conn_id = cmd_reg.conn_id;

    assign cur_entry   = entry_fields_reg[scan_idx_reg];
    assign cur_present = valid_reg[scan_idx_reg];
    assign in_range    = cmd.index < 8'(SLOTS);

    sest_cmp u_cmp (
        .entry   (cur_entry),
        .present (cur_present),
        .key     (key),
        .res     (cmp)
    );

    assign wr_en = (state_reg == S_FINISH) && (cmd_reg.operation == OP_ADD) &&
                   !hit_found_reg && free_found_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_fields_reg[free_idx_reg] <= key;
        end
    end

    always_comb
    begin
        result_next       = '0;
        result_next.count = sat_count(count_reg);
        case (cmd_reg.operation)
            OP_ADD:
            begin
                if (hit_found_reg)
                begin
                    result_next.status = ST_PRESENT;
                end
                else if (free_found_reg)
                begin
                    result_next.status = ST_DONE;
                    result_next.count  = sat_count(count_reg + 1'b1);
                end
                else
                begin
                    result_next.status = ST_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (hit_found_reg)
                begin
                    result_next.status = ST_DONE;
                    result_next.count  = sat_count(count_reg - 1'b1);
                end
                else
                begin
                    result_next.status = ST_NOT_FOUND;
                end
            end
            OP_READ:
            begin
                if (cmd_reg.index >= 8'(SLOTS))
                begin
                    result_next.status      = ST_RANGE;
                    result_next.out_channel = SENT_16;
                    result_next.out_slot    = SENT_8;
                    result_next.out_shelf   = SENT_8;
                    result_next.out_conn_id = SENT_16;
                end
                else if (cur_present)
                begin
                    result_next.status      = ST_DONE;
                    result_next.entry_valid = 1'b1;
                    result_next.out_channel = cur_entry.channel;
                    result_next.out_slot    = cur_entry.slot;
                    result_next.out_shelf   = cur_entry.shelf;
                    result_next.out_conn_id = cur_entry.conn_id;
                end
                else
                begin
                    result_next.status = ST_DONE;
                end
            end
            OP_CLEAR:
            begin
                result_next.status = ST_DONE;
                result_next.count  = 3'd0;
            end
            default:
            begin
                result_next.status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            done_reg       <= 1'b0;
            cmd_reg        <= '0;
            result_reg     <= '0;
        end
        else
        begin
            done_reg <= (state_reg == S_FINISH);
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg        <= cmd;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        if (cmd.operation inside {OP_ADD, OP_REMOVE})
                        begin
                            scan_idx_reg <= '0;
                            state_reg    <= S_SCAN;
                        end
                        else
                        begin
                            // read goes through the same entry port as the scan
                            if (in_range)
                            begin
                                scan_idx_reg <= cmd.index[IDX_W-1:0];
                            end
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (cmp.hit && !hit_found_reg)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_idx_reg   <= scan_idx_reg;
                    end
                    if (cmp.free && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= scan_idx_reg;
                    end
                    if (scan_idx_reg == IDX_W'(SLOTS - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                S_FINISH:
                begin
                    state_reg  <= S_IDLE;
                    result_reg <= result_next;
                    case (cmd_reg.operation)
                        OP_ADD:
                        begin
                            if (!hit_found_reg && free_found_reg)
                            begin
                                valid_reg[free_idx_reg] <= 1'b1;
                                count_reg               <= count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (hit_found_reg)
                            begin
                                valid_reg[hit_idx_reg] <= 1'b0;
                                count_reg              <= count_reg - 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            valid_reg <= '0;
                            count_reg <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("occupancy count differs from valid bits");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("occupancy count above table size");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without work in progress");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> count_reg == CNT_W'(SLOTS))
        else $error("table full reported with free entries");

endmodule

>>> hw/rtl/sest_cmp.sv
module sest_cmp
    import sest_pkg::*;
(
    input  sest_entry_t entry,
    input  logic        present,
    input  sest_entry_t key,
    output sest_cmp_t   res
);

    // exact four-field match against one stored entry
    always_comb
    begin
        res.hit  = present && (entry.channel == key.channel) && (entry.slot == key.slot) &&
                   (entry.shelf == key.shelf) && (entry.conn_id == key.conn_id);
        res.free = !present;
    end

endmodule
